// ===== hw/rtl/ffta_pkg.sv =====
`default_nettype none
package ffta_pkg;

  localparam int DEF_TABLE_ENTRIES = 16;
  localparam int DEF_ADDR_BITS     = 16;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int SIZE_W = 16;
  localparam int ST_W   = 3;
  localparam int DATA_W = 32;
  localparam int PADDR_W = 2;

  localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE_ALL = 2'd2;

  localparam logic [ST_W-1:0] STAT_REUSED    = 3'd0;
  localparam logic [ST_W-1:0] STAT_NEW       = 3'd1;
  localparam logic [ST_W-1:0] STAT_FULL      = 3'd2;
  localparam logic [ST_W-1:0] STAT_FREED     = 3'd3;
  localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd4;
  localparam logic [ST_W-1:0] STAT_ALL_FREED = 3'd5;

  typedef struct packed {
    logic ge;
    logic eq;
  } ffta_flags_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ffta_if.sv =====
`default_nettype none
interface ffta_in_if import ffta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] block_address;

  modport source (output valid, operation, request_size, block_address, input ready);
  modport sink   (input valid, operation, request_size, block_address, output ready);
endinterface

interface ffta_out_if import ffta_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] result_address;
  logic [ST_W-1:0]   status;

  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/ffta_alu.sv =====
`default_nettype none
module ffta_alu import ffta_pkg::*; #(
  parameter int W = 16
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] diff,
  output ffta_flags_t       flags
);

  logic [W:0] full_diff;

  // one subtractor serves size compare, address match and pointer update
  assign full_diff = {1'b0, a} - {1'b0, b};
  assign diff      = full_diff[W-1:0];
  assign flags.ge  = ~full_diff[W];
  assign flags.eq  = (full_diff == '0);

endmodule
`default_nettype wire

// ===== hw/rtl/ffta_rec_mem.sv =====
`default_nettype none
module ffta_rec_mem #(
  parameter int DEPTH = 16,
  parameter int DW    = 33
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DW-1:0]            wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DW-1:0]            rdata
);

  logic [DW-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_table_allocator_core.sv =====
// free_all and unknown ops go from accept straight to S_DONE and the result word
// alloc scans the used records in S_SCAN, then appends in S_APPEND on a miss; free scans the used records
// one record read per cycle from the record memory through the shared subtractor
// one word in flight: ready only while idle
// a result word held by out_ch.ready stalls the next result in S_DONE until it drains
// reset: rst_n synchronous, clears pointer, count, base and output valid; records are not cleared
`default_nettype none
module first_fit_table_allocator_core import ffta_pkg::*; #(
  parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
  parameter int ADDR_BITS     = DEF_ADDR_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ffta_in_if.sink                 in_ch,
  ffta_out_if.source              out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int UW = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam int RW = ADDR_BITS + SIZE_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic                 chk_v_r, chk_v_nxt;
  logic [IW-1:0]        chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  logic [ADDR_BITS-1:0] fp_r, fp_nxt;
  logic [ADDR_W-1:0]    base_r;
  logic [OP_W-1:0]      op_r;
  logic [SIZE_W-1:0]    req_r;
  logic [ADDR_BITS-1:0] baddr_r;
  logic [ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic [ST_W-1:0]      res_st_r, res_st_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [ST_W-1:0]      out_st_r, out_st_nxt;

  logic                 in_acc;
  logic                 mem_we;
  logic [IW-1:0]        mem_waddr;
  logic [RW-1:0]        mem_wdata;
  logic [RW-1:0]        rec_rd;
  logic [ADDR_BITS-1:0] rec_addr;
  logic [SIZE_W-1:0]    rec_size;
  logic                 rec_free;
  logic [UW-1:0]        alu_a, alu_b, alu_diff;
  ffta_flags_t          alu_flags;
  logic [ADDR_BITS-1:0] new_fp;
  logic                 hit;
  logic                 last_chk;

  // apb register
  assign pready = 1'b1;
  assign prdata = DATA_W'(base_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (psel && penable && pwrite && (paddr == '0)) begin
      base_r <= pwdata[ADDR_W-1:0];
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid          = out_v_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.status         = out_st_r;

  ffta_rec_mem #(
    .DEPTH (TABLE_ENTRIES),
    .DW    (RW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r[IW-1:0]),
    .rdata (rec_rd)
  );

  assign rec_addr = rec_rd[ADDR_BITS-1:0];
  assign rec_size = rec_rd[ADDR_BITS +: SIZE_W];
  assign rec_free = rec_rd[RW-1];

  always_comb begin
    priority if (state_r == S_APPEND) begin
      alu_a = UW'(fp_r);
      alu_b = UW'(req_r);
    end else if (op_r == OP_FREE) begin
      alu_a = UW'(rec_addr);
      alu_b = UW'(baddr_r);
    end else begin
      alu_a = UW'(rec_size);
      alu_b = UW'(req_r);
    end
  end

  ffta_alu #(.W(UW)) u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .diff  (alu_diff),
    .flags (alu_flags)
  );

  assign new_fp   = alu_diff[ADDR_BITS-1:0];
  assign hit      = (op_r == OP_ALLOC) ? (rec_free && alu_flags.ge) : alu_flags.eq;
  assign last_chk = ((CW'(chk_idx_r) + CW'(1)) == used_r);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    chk_v_nxt    = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    used_nxt     = used_r;
    fp_nxt       = fp_r;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    out_v_nxt    = out_v_r && !out_ch.ready;
    out_addr_nxt = out_addr_r;
    out_st_nxt   = out_st_r;
    mem_we       = 1'b0;
    mem_waddr    = chk_idx_r;
    mem_wdata    = {op_r == OP_FREE, rec_size, rec_addr};
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_addr_nxt = '0;
          res_st_nxt   = STAT_NOT_FOUND;
          state_nxt    = S_DONE;
          priority if (in_ch.operation == OP_FREE_ALL) begin
            fp_nxt     = ADDR_BITS'(UW'(base_r));
            used_nxt   = '0;
            res_st_nxt = STAT_ALL_FREED;
          end else if (in_ch.operation == OP_ALLOC || in_ch.operation == OP_FREE) begin
            if (used_r != '0) begin
              state_nxt = S_SCAN;
              idx_nxt   = '0;
            end else if (in_ch.operation == OP_ALLOC) begin
              state_nxt = S_APPEND;
            end
          end else begin
            res_st_nxt = STAT_NOT_FOUND;
          end
        end
      end
      S_SCAN: begin
        if (idx_r < used_r) begin
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = idx_r[IW-1:0];
          idx_nxt     = idx_r + CW'(1);
        end
        if (chk_v_r) begin
          if (hit) begin
            mem_we    = 1'b1;
            state_nxt = S_DONE;
            if (op_r == OP_ALLOC) begin
              res_addr_nxt = ADDR_W'(UW'(rec_addr));
              res_st_nxt   = STAT_REUSED;
            end else begin
              res_st_nxt = STAT_FREED;
              if (last_chk) begin
                used_nxt = used_r - CW'(1);
              end
            end
          end else if (last_chk) begin
            if (op_r == OP_ALLOC) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end
      end
      S_APPEND: begin
        fp_nxt       = new_fp;
        res_addr_nxt = ADDR_W'(UW'(new_fp));
        state_nxt    = S_DONE;
        if (used_r != CW'(TABLE_ENTRIES)) begin
          mem_we     = 1'b1;
          mem_waddr  = used_r[IW-1:0];
          mem_wdata  = {1'b0, req_r, new_fp};
          used_nxt   = used_r + CW'(1);
          res_st_nxt = STAT_NEW;
        end else begin
          res_st_nxt = STAT_FULL;
        end
      end
      S_DONE: begin
        if (!out_v_r || out_ch.ready) begin
          out_v_nxt    = 1'b1;
          out_addr_nxt = res_addr_r;
          out_st_nxt   = res_st_r;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      chk_v_r <= 1'b0;
      used_r  <= '0;
      fp_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      chk_v_r <= chk_v_nxt;
      used_r  <= used_nxt;
      fp_r    <= fp_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    if (in_acc) begin
      op_r    <= in_ch.operation;
      req_r   <= in_ch.request_size;
      baddr_r <= ADDR_BITS'(UW'(in_ch.block_address));
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(TABLE_ENTRIES))
    else $error("used count beyond table size");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> used_r != '0)
    else $error("scan with empty table");

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_SCAN || state_r == S_APPEND))
    else $error("record write outside scan or append");

  a_append_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we && state_r == S_APPEND |=> used_r == $past(used_r) + CW'(1))
    else $error("append did not grow the table");

  a_free_all: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_ch.operation == OP_FREE_ALL |=> used_r == '0 && state_r == S_DONE)
    else $error("free all did not empty the table");

endmodule
`default_nettype wire

// ===== test/first_fit_table_allocator_checker.sv =====
`timescale 1ns / 1ps
module first_fit_table_allocator_checker import ffta_pkg::*; #(
  parameter logic [PADDR_W-1:0] BASE_REG_ADDR = '0
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  ffta_in_if                      in_mon,
  ffta_out_if                     out_mon,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic               pready,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output int                      pending,
  output int                      mismatches
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ST_W-1:0]   status;
  } alloc_result_t;

  logic [ADDR_W-1:0] base_reg;
  logic [ADDR_W-1:0] free_ptr;
  logic [ADDR_W-1:0] rec_addr [DEF_TABLE_ENTRIES];
  logic [SIZE_W-1:0] rec_size [DEF_TABLE_ENTRIES];
  logic              rec_free [DEF_TABLE_ENTRIES];
  int unsigned       used_cnt;
  alloc_result_t     expected_results [$];

  function automatic alloc_result_t apply_word(input logic [OP_W-1:0] op,
                                               input logic [SIZE_W-1:0] sz,
                                               input logic [ADDR_W-1:0] ba);
    alloc_result_t r;
    bit hit;
    int unsigned i;
    r.addr = '0;
    r.status = STAT_NOT_FOUND;
    hit = 1'b0;
    case (op)
      OP_ALLOC: begin
        for (i = 0; i < used_cnt && !hit; i++) begin
          if (rec_free[i] && rec_size[i] >= sz) begin
            hit = 1'b1;
            rec_free[i] = 1'b0;
            r.addr = rec_addr[i];
            r.status = STAT_REUSED;
          end
        end
        if (!hit) begin
          free_ptr = free_ptr - sz;
          if (used_cnt < DEF_TABLE_ENTRIES) begin
            rec_addr[used_cnt] = free_ptr;
            rec_size[used_cnt] = sz;
            rec_free[used_cnt] = 1'b0;
            used_cnt++;
            r.status = STAT_NEW;
          end else begin
            r.status = STAT_FULL;
          end
          r.addr = free_ptr;
        end
      end
      OP_FREE: begin
        for (i = 0; i < used_cnt && !hit; i++) begin
          if (rec_addr[i] == ba) begin
            hit = 1'b1;
            rec_free[i] = 1'b1;
            if (i + 1 == used_cnt) used_cnt--;
            r.status = STAT_FREED;
          end
        end
      end
      OP_FREE_ALL: begin
        free_ptr = base_reg;
        for (i = 0; i < DEF_TABLE_ENTRIES; i++) rec_free[i] = 1'b1;
        used_cnt = 0;
        r.status = STAT_ALL_FREED;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      base_reg = '0;
      free_ptr = '0;
      used_cnt = 0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == BASE_REG_ADDR)
        base_reg = pwdata[ADDR_W-1:0];
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(apply_word(in_mon.operation, in_mon.request_size,
                                              in_mon.block_address));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with nothing pending: result_address %h status %0d",
                 out_mon.result_address, out_mon.status);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.result_address !== exp_r.addr) begin
            $error("result_address: expected %h, got %h", exp_r.addr,
                   out_mon.result_address);
            mismatches++;
          end
          if (out_mon.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_mon.status);
            mismatches++;
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== test/first_fit_table_allocator_core_tb.sv =====
`timescale 1ns / 1ps
module first_fit_table_allocator_core_tb;
  import ffta_pkg::*;

  localparam logic [PADDR_W-1:0] BASE_REG_ADDR = '0;
  localparam int RANDOM_WORDS_PER_PHASE = 220;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  int pending;
  int mismatches;
  int words_sent = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;
  logic [ADDR_W-1:0] issued_addrs [$];

  ffta_in_if in_ch ();
  ffta_out_if out_ch ();

  always #5 clk = ~clk;

  first_fit_table_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  first_fit_table_allocator_checker #(
    .BASE_REG_ADDR (BASE_REG_ADDR)
  ) alloc_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .mismatches (mismatches)
  );

  // addresses handed out by alloc, reused as free targets
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready &&
        (out_ch.status == STAT_REUSED || out_ch.status == STAT_NEW ||
         out_ch.status == STAT_FULL)) begin
      issued_addrs.push_back(out_ch.result_address);
      if (issued_addrs.size() > 24) void'(issued_addrs.pop_front());
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  task automatic write_base(input logic [ADDR_W-1:0] base);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = BASE_REG_ADDR;
    pwdata = {(DATA_W - ADDR_W)'($urandom), base};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] sz,
                           input logic [ADDR_W-1:0] ba);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.request_size = sz;
    in_ch.block_address = ba;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain_words();
    in_ch.valid = 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SIZE_W'($urandom);
      2: return SIZE_W'(16'hFFFF - $urandom_range(0, 3));
      default: return SIZE_W'($urandom_range(1, 64));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] pick_issued();
    if (issued_addrs.size() == 0) return ADDR_W'($urandom);
    return issued_addrs[$urandom_range(0, issued_addrs.size() - 1)];
  endfunction

  task automatic run_episode();
    int n;
    int k;
    int r;
    if ($urandom_range(0, 9) < 7) begin
      send_word(OP_FREE_ALL, SIZE_W'($urandom), ADDR_W'($urandom));
      n = $urandom_range(8, 40);
      for (k = 0; k < n; k++) begin
        r = $urandom_range(0, 19);
        if (r <= 8)
          send_word(OP_ALLOC, pick_size(), ADDR_W'($urandom));
        else if (r <= 15)
          send_word(OP_FREE, SIZE_W'($urandom), pick_issued());
        else if (r == 16)
          send_word(OP_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
        else if (r == 17)
          send_word(OP_W'(3), SIZE_W'($urandom), ADDR_W'($urandom));
        else if (r == 18)
          send_word(OP_ALLOC, '0, ADDR_W'($urandom));
        else
          send_word(OP_ALLOC, SIZE_W'($urandom), ADDR_W'($urandom));
      end
    end else begin
      n = $urandom_range(4, 12);
      for (k = 0; k < n; k++)
        send_word(OP_W'($urandom_range(0, 3)), SIZE_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] phase_base [5];
    int ph;
    int target;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.request_size = '0;
    in_ch.block_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    phase_base[0] = 16'h0000;
    phase_base[1] = 16'hFFFF;
    phase_base[2] = ADDR_W'($urandom);
    phase_base[3] = 16'h0040;
    phase_base[4] = ADDR_W'($urandom);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    write_base(16'h1000);
    send_word(OP_FREE_ALL, '0, '0);
    send_word(OP_ALLOC, 16'h0000, '0);
    send_word(OP_ALLOC, 16'hFFFF, 16'hFFFF);
    send_word(OP_ALLOC, 16'h0010, '0);
    send_word(OP_FREE, '0, 16'h0FF1);
    send_word(OP_FREE, '0, 16'h1000);
    send_word(OP_ALLOC, 16'h0000, '0);
    send_word(OP_FREE, '0, 16'h1001);
    send_word(OP_ALLOC, 16'h0005, '0);
    send_word(OP_ALLOC, 16'h0000, '0);
    send_word(OP_FREE, '0, 16'h0FEC);
    send_word(OP_FREE, 16'hFFFF, 16'hFFFF);
    send_word(OP_FREE, '0, 16'h0000);
    send_word(OP_W'(3), 16'hFFFF, 16'hFFFF);
    send_word(OP_ALLOC, 16'h0003, '0);
    send_word(OP_W'(3), '0, '0);
    send_word(OP_FREE_ALL, 16'hFFFF, 16'hFFFF);

    for (ph = 0; ph < 5; ph++) begin
      drain_words();
      write_base(phase_base[ph]);
      idle_on = (ph != 2 && ph != 4);
      target = words_sent + RANDOM_WORDS_PER_PHASE;
      while (words_sent < target) run_episode();
    end

    drain_words();
    repeat (3 * DEF_TABLE_ENTRIES) @(negedge clk);
    if (mismatches == 0) begin
      $display("first_fit_table_allocator_core_tb: clean");
    end else begin
      $display("first_fit_table_allocator_core_tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("first_fit_table_allocator_core_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/ffta_pkg.sv
hw/rtl/ffta_if.sv
hw/rtl/ffta_alu.sv
hw/rtl/ffta_rec_mem.sv
hw/rtl/first_fit_table_allocator_core.sv
test/first_fit_table_allocator_checker.sv
test/first_fit_table_allocator_core_tb.sv
